// ----- design/i2cm_pkg.sv -----
package i2cm_pkg;

    localparam int TICK_W   = 16;
    localparam int PHASE_W  = 5;
    localparam int BYTE_W   = 8;
    localparam int MODE_W   = 3;
    localparam int S_DATA_W = 16;
    localparam int M_DATA_W = 16;

    // Command codes; a tick and the idle command share code zero
    localparam logic [MODE_W-1:0] MODE_TICK = 3'd0;
    localparam logic [MODE_W-1:0] CMD_IDLE  = 3'd0;
    localparam logic [MODE_W-1:0] CMD_START = 3'd1;
    localparam logic [MODE_W-1:0] CMD_STOP  = 3'd2;
    localparam logic [MODE_W-1:0] CMD_WRITE = 3'd3;
    localparam logic [MODE_W-1:0] CMD_ACK   = 3'd4;
    localparam logic [MODE_W-1:0] CMD_READ  = 3'd5;

    localparam logic [TICK_W-1:0] PHASE_TICKS_RST = 16'd2;

    // Result bit positions on m_tdata
    localparam int RES_SCL_BIT  = 0;
    localparam int RES_SDA_BIT  = 1;
    localparam int RES_BUSY_BIT = 2;
    localparam int RES_DONE_BIT = 3;
    localparam int RES_NACK_BIT = 12;
    localparam int RES_REJ_BIT  = 13;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic              sda_level;
        logic              send_nack;
        logic [BYTE_W-1:0] tx_data;
    } item_t;

    // scl_drive lands in bit 0
    typedef struct packed {
        logic              cmd_rejected;
        logic              nack_seen;
        logic [BYTE_W-1:0] rx_byte;
        logic              done_res;
        logic              busy_res;
        logic              sda_drive;
        logic              scl_drive;
    } result_t;

    typedef struct packed {
        logic scl;
        logic sda;
    } pins_t;

    function automatic logic [PHASE_W-1:0] phase_count(input logic [MODE_W-1:0] cmd);
        logic [PHASE_W-1:0] n;
        unique case (cmd)
            CMD_START: n = 5'd3;
            CMD_STOP:  n = 5'd2;
            CMD_WRITE: n = 5'd24;
            CMD_ACK:   n = 5'd3;
            CMD_READ:  n = 5'd19;
            default:   n = 5'd0;
        endcase
        return n;
    endfunction

    // Pin levels set on entry to phase p; p3 is p mod 3 (write byte only)
    function automatic pins_t enter_phase(input logic [MODE_W-1:0]  cmd,
                                          input logic [PHASE_W-1:0] p,
                                          input logic [1:0]         p3,
                                          input logic               msb,
                                          input logic               ans,
                                          input pins_t              cur);
        pins_t nx;
        nx = cur;
        unique case (cmd)
            CMD_START: begin
                if (p == 5'd0) begin
                    nx.sda = 1'b1;
                    nx.scl = 1'b1;
                end else if (p == 5'd1) begin
                    nx.sda = 1'b0;
                end else begin
                    nx.scl = 1'b0;
                end
            end
            CMD_STOP: begin
                if (p == 5'd0) begin
                    nx.sda = 1'b0;
                    nx.scl = 1'b1;
                end else begin
                    nx.sda = 1'b1;
                end
            end
            CMD_ACK: begin
                if (p == 5'd0) begin
                    nx.sda = 1'b1;
                end else if (p == 5'd1) begin
                    nx.scl = 1'b1;
                end else begin
                    nx.scl = 1'b0;
                end
            end
            CMD_WRITE: begin
                if (p3 == 2'd0) begin
                    nx.sda = msb;
                end else if (p3 == 2'd1) begin
                    nx.scl = 1'b1;
                end else begin
                    nx.scl = 1'b0;
                end
            end
            CMD_READ: begin
                if (!p[4]) begin
                    nx.scl = ~p[0];
                end else if (p == 5'd16) begin
                    nx.sda = ans;
                    nx.scl = 1'b0;
                end else if (p == 5'd17) begin
                    nx.scl = 1'b1;
                end else begin
                    nx.scl = 1'b0;
                end
            end
            default: begin
                nx = cur;
            end
        endcase
        return nx;
    endfunction

endpackage

// ----- design/i2cm_seq.sv -----
// Bus sequencer: command state, phase/tick counters, shift register, pins.
module i2cm_seq
    import i2cm_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                step_en,
    input  item_t               item,
    input  logic [TICK_W-1:0]   phase_ticks,
    output result_t             result
);

    logic [MODE_W-1:0]  cmd_reg,   cmd_next;
    logic [PHASE_W-1:0] phase_reg, phase_next;
    logic [1:0]         ph3_reg,   ph3_next;
    logic [TICK_W-1:0]  tick_reg,  tick_next;
    logic [BYTE_W-1:0]  shift_reg, shift_next;
    logic [BYTE_W-1:0]  rxb_reg,   rxb_next;
    pins_t              pins_reg,  pins_next;
    logic               nack_reg,  nack_next;
    logic               ans_reg,   ans_next;
    logic               done, rejected;

    always_comb begin
        logic [TICK_W:0]    tick_sum;
        logic [TICK_W-1:0]  limit;
        logic [PHASE_W-1:0] p_inc;
        logic [1:0]         p3_inc;
        logic [BYTE_W-1:0]  sample_mask;
        logic               busy;
        pins_t              pins_start;

        cmd_next   = cmd_reg;
        phase_next = phase_reg;
        ph3_next   = ph3_reg;
        tick_next  = tick_reg;
        shift_next = shift_reg;
        rxb_next   = rxb_reg;
        pins_next  = pins_reg;
        nack_next  = nack_reg;
        ans_next   = ans_reg;
        done       = 1'b0;
        rejected   = 1'b0;

        busy        = (cmd_reg != CMD_IDLE);
        limit       = (phase_ticks == '0) ? TICK_W'(1) : phase_ticks;
        tick_sum    = {1'b0, tick_reg} + (TICK_W+1)'(1);
        p_inc       = phase_reg + PHASE_W'(1);
        p3_inc      = (ph3_reg == 2'd2) ? 2'd0 : ph3_reg + 2'd1;
        sample_mask = 8'h80 >> phase_reg[3:1];
        pins_start  = pins_reg;

        if (item.mode == MODE_TICK) begin
            if (busy) begin
                tick_next = tick_sum[TICK_W-1:0];
                if (tick_sum >= {1'b0, limit}) begin
                    tick_next = '0;
                    if (cmd_reg == CMD_ACK && phase_reg == 5'd1 && item.sda_level) begin
                        // NACK: flag it and fall into the stop sequence
                        nack_next  = 1'b1;
                        cmd_next   = CMD_STOP;
                        phase_next = '0;
                        ph3_next   = 2'd0;
                        pins_next  = enter_phase(CMD_STOP, '0, 2'd0, 1'b0, ans_reg, pins_reg);
                    end else begin
                        if (cmd_reg == CMD_ACK && phase_reg == 5'd1) begin
                            nack_next = 1'b0;
                        end
                        if (cmd_reg == CMD_WRITE && ph3_reg == 2'd2) begin
                            shift_next = {shift_reg[BYTE_W-2:0], 1'b0};
                        end
                        if (cmd_reg == CMD_READ && !phase_reg[4] && !phase_reg[0]
                            && item.sda_level) begin
                            shift_next = shift_reg | sample_mask;
                        end
                        if (p_inc >= phase_count(cmd_reg)) begin
                            if (cmd_reg == CMD_WRITE) begin
                                pins_next.sda = 1'b1;
                            end
                            if (cmd_reg == CMD_READ) begin
                                rxb_next = shift_next;
                            end
                            cmd_next   = CMD_IDLE;
                            phase_next = '0;
                            ph3_next   = 2'd0;
                            done       = 1'b1;
                        end else begin
                            phase_next = p_inc;
                            ph3_next   = p3_inc;
                            pins_next  = enter_phase(cmd_reg, p_inc, p3_inc,
                                                     shift_next[BYTE_W-1], ans_reg, pins_reg);
                        end
                    end
                end
            end
        end else if (item.mode <= CMD_READ) begin
            if (busy) begin
                rejected = 1'b1;
            end else begin
                cmd_next   = item.mode;
                phase_next = '0;
                ph3_next   = 2'd0;
                tick_next  = '0;
                if (item.mode == CMD_WRITE) begin
                    shift_next = item.tx_data;
                end
                if (item.mode == CMD_READ) begin
                    shift_next     = '0;
                    ans_next       = item.send_nack;
                    pins_start.scl = 1'b0;
                end
                pins_next = enter_phase(item.mode, '0, 2'd0, shift_next[BYTE_W-1],
                                        ans_next, pins_start);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cmd_reg   <= CMD_IDLE;
            phase_reg <= '0;
            ph3_reg   <= 2'd0;
            tick_reg  <= '0;
            shift_reg <= '0;
            rxb_reg   <= '0;
            pins_reg  <= '{scl: 1'b1, sda: 1'b1};
            nack_reg  <= 1'b0;
            ans_reg   <= 1'b0;
        end else if (step_en) begin
            cmd_reg   <= cmd_next;
            phase_reg <= phase_next;
            ph3_reg   <= ph3_next;
            tick_reg  <= tick_next;
            shift_reg <= shift_next;
            rxb_reg   <= rxb_next;
            pins_reg  <= pins_next;
            nack_reg  <= nack_next;
            ans_reg   <= ans_next;
        end
    end

    always_comb begin
        result.scl_drive    = pins_next.scl;
        result.sda_drive    = pins_next.sda;
        result.busy_res     = (cmd_next != CMD_IDLE);
        result.done_res     = done;
        result.rx_byte      = rxb_next;
        result.nack_seen    = nack_next;
        result.cmd_rejected = rejected;
    end

endmodule

// ----- design/i2c_bit_level_master_core.sv -----
// Channel   Dir  Handshake          Payload
// s_        in   s_tvalid/s_tready  s_tuser = mode, s_tdata = tx_data, send_nack, sda_level
// m_        out  m_tvalid/m_tready  m_tdata = pin levels, status flags, rx_byte
// cfg_      in   cfg_we             cfg_wdata = phase_ticks
//
// One request per clock is accepted while the result register is not stalled.
// A request waits in the input register, then the sequencer update loads
// its result into the result register.
// Reset (aresetn low, synchronous) empties both registers, idles the bus
// (SCL and SDA released) and sets phase_ticks to 2.
// A stalled result holds in the result register; the input register keeps
// taking a request until it is itself full behind the stall.
module i2c_bit_level_master_core
    import i2cm_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    // [7:0] tx_data, [8] send_nack, [9] sda_level, [15:10] unused
    input  logic [S_DATA_W-1:0] s_tdata,
    // [2:0] mode
    input  logic [MODE_W-1:0]   s_tuser,
    output logic                m_tvalid,
    input  logic                m_tready,
    // [0] scl_drive, [1] sda_drive, [2] busy_res, [3] done_res,
    // [11:4] rx_byte, [12] nack_seen, [13] cmd_rejected, [15:14] zero
    output logic [M_DATA_W-1:0] m_tdata,
    input  logic                cfg_we,
    input  logic [TICK_W-1:0]   cfg_wdata
);

    logic               in_valid_reg;
    item_t              in_item_reg;
    logic               out_valid_reg;
    result_t            out_data_reg;
    logic [TICK_W-1:0]  phase_ticks_reg;
    logic               advance;
    result_t            step_result;

    // Sequencer steps once the result register can take the outcome
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_item_reg <= '{mode:      s_tuser,
                             sda_level: s_tdata[9],
                             send_nack: s_tdata[8],
                             tx_data:   s_tdata[7:0]};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_ticks_reg <= PHASE_TICKS_RST;
        end else if (cfg_we) begin
            phase_ticks_reg <= cfg_wdata;
        end
    end

    i2cm_seq u_seq (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .step_en     (advance),
        .item        (in_item_reg),
        .phase_ticks (phase_ticks_reg),
        .result      (step_result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_data_reg <= step_result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(M_DATA_W - $bits(result_t))'(0), out_data_reg};

endmodule

// ----- design/i2cm_checker.sv -----
module i2cm_checker
    import i2cm_pkg::*;
(
    input logic                aclk,
    input logic                aresetn,
    input logic                s_tready,
    input logic                m_tvalid,
    input logic                m_tready,
    input logic [M_DATA_W-1:0] m_tdata
);

    // stalled result holds
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed under stall");

    // a finishing sequence leaves the master idle
    a_done_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[RES_DONE_BIT] |-> !m_tdata[RES_BUSY_BIT])
        else $error("done with busy set");

    // a rejected command leaves the running sequence busy
    a_rej_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[RES_REJ_BIT] |-> m_tdata[RES_BUSY_BIT]
            && !m_tdata[RES_DONE_BIT])
        else $error("reject flagged outside a sequence");

    // reset empties the result register and opens the input
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && s_tready)
        else $error("not empty after reset");

endmodule

bind i2c_bit_level_master_core i2cm_checker u_i2cm_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
